// ===== hw/rtl/voxel_scatter_reduce_core_macros.svh =====
// assertion macros for the voxel scatter reduce core
`ifndef VOXEL_SCATTER_REDUCE_CORE_MACROS_SVH
`define VOXEL_SCATTER_REDUCE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define VSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vsr_pkg.sv =====
package vsr_pkg;

    // feature lanes on the ports
    localparam int N_FEAT = 8;
    localparam int FEAT_W = 16;
    localparam int ACC_W  = 32;
    localparam int CNT_W  = 16;
    localparam int GRID_W = 13;
    localparam int CFG_IDX_W = 3;

    // reduction modes
    localparam logic [1:0] MODE_SUM  = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIDX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIDY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIDZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATS = 3'd4;

    // item kinds
    localparam logic KIND_SCATTER = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [GRID_W-1:0] grid_x;
        logic [GRID_W-1:0] grid_y;
        logic [GRID_W-1:0] grid_z;
        logic [3:0]        feats;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic                          kind;
        logic                          ok;
        logic [N_FEAT-1:0][FEAT_W-1:0] feat;
    } t_cmd;

endpackage

// ===== hw/rtl/voxel_scatter_reduce_core.sv =====
// voxel scatter reduce core
// input channel (i_in_valid / o_in_ready): kind 0 scatters a point into the
// voxel at x*Y*Z+y*Z+z, kind 1 reads that voxel's sum, mean or max and clears
// it. points outside the grid or beyond capacity are dropped; reads of them
// return zeros with in_range low. only read items produce a result item.
// output channel (o_out_valid / i_out_ready) is held in an output register,
// so the core keeps working while a result waits to be taken.
// structure: a front pipeline of two stages classifies each item and queues it
// (four entries); the back sequencer reads the voxel word from the store
// (registered read) and writes it back in the next cycle. a scatter passes the
// back through its idle and exec states, a sum or max read also through its
// output state, a mean read as well through 32 radix-2 division steps (all
// lanes in parallel). a sum or max result passes the two front stages, the
// queue and the exec and output states before it appears.
// the back takes one item at a time: it pops no new item from the queue until
// it is idle again. reset: a clearing sweep zeroes the store, one voxel per
// cycle; o_in_ready stays low meanwhile, config writes still land.
// when the receiver stalls, the queue fills and o_in_ready drops.
`include "voxel_scatter_reduce_core_macros.svh"

module voxel_scatter_reduce_core #(
    parameter int MAX_VOXELS = 4096,
    parameter int LANES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vsr_pkg::GRID_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic signed [15:0]              i_coord_x,
    input  logic signed [15:0]              i_coord_y,
    input  logic signed [15:0]              i_coord_z,
    input  logic signed [15:0]              i_feat_0,
    input  logic signed [15:0]              i_feat_1,
    input  logic signed [15:0]              i_feat_2,
    input  logic signed [15:0]              i_feat_3,
    input  logic signed [15:0]              i_feat_4,
    input  logic signed [15:0]              i_feat_5,
    input  logic signed [15:0]              i_feat_6,
    input  logic signed [15:0]              i_feat_7,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_out_0,
    output logic signed [31:0]              o_out_1,
    output logic signed [31:0]              o_out_2,
    output logic signed [31:0]              o_out_3,
    output logic signed [31:0]              o_out_4,
    output logic signed [31:0]              o_out_5,
    output logic signed [31:0]              o_out_6,
    output logic signed [31:0]              o_out_7,
    output logic [15:0]                     o_point_count,
    output logic                            o_in_range
);

    localparam int IW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
    localparam int QW = IW + $bits(vsr_pkg::t_cmd);

    vsr_pkg::t_cfg r_cfg;
    logic          clearing;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    vsr_pkg::t_cmd f_cmd;
    vsr_pkg::t_cmd b_cmd;
    logic [IW-1:0] f_idx;
    logic [IW-1:0] b_idx;
    logic [QW-1:0] q_out;
    logic [vsr_pkg::ACC_W-1:0] lane [vsr_pkg::N_FEAT];
    logic [vsr_pkg::N_FEAT-1:0][vsr_pkg::FEAT_W-1:0] feat;

    assign feat = {i_feat_7, i_feat_6, i_feat_5, i_feat_4,
                   i_feat_3, i_feat_2, i_feat_1, i_feat_0};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= vsr_pkg::MODE_SUM;
            r_cfg.grid_x <= 13'd16;
            r_cfg.grid_y <= 13'd16;
            r_cfg.grid_z <= 13'd16;
            r_cfg.feats  <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vsr_pkg::CFG_MODE:  r_cfg.mode   <= i_cfg_data[1:0];
                vsr_pkg::CFG_GRIDX: r_cfg.grid_x <= i_cfg_data;
                vsr_pkg::CFG_GRIDY: r_cfg.grid_y <= i_cfg_data;
                vsr_pkg::CFG_GRIDZ: r_cfg.grid_z <= i_cfg_data;
                vsr_pkg::CFG_FEATS: r_cfg.feats  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    vsr_front #(
        .MAX_VOXELS (MAX_VOXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_block (clearing),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_kind  (i_kind),
        .i_x     (i_coord_x),
        .i_y     (i_coord_y),
        .i_z     (i_coord_z),
        .i_feat  (feat),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .o_idx   (f_idx),
        .i_full  (full)
    );

    vsr_fifo #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_idx, f_cmd}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign b_idx = q_out[QW-1 -: IW];
    assign b_cmd = q_out[$bits(vsr_pkg::t_cmd)-1:0];

    vsr_back #(
        .MAX_VOXELS (MAX_VOXELS),
        .LANES      (LANES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (clearing),
        .i_empty    (empty),
        .i_cmd      (b_cmd),
        .i_idx      (b_idx),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_lane     (lane),
        .o_count    (o_point_count),
        .o_in_range (o_in_range)
    );

    assign o_out_0 = lane[0];
    assign o_out_1 = lane[1];
    assign o_out_2 = lane[2];
    assign o_out_3 = lane[3];
    assign o_out_4 = lane[4];
    assign o_out_5 = lane[5];
    assign o_out_6 = lane[6];
    assign o_out_7 = lane[7];

    // checks on the internal hand-off
    `VSR_ASSERT_NOW(a_no_push_full, push, !full, "queue push while full")
    `VSR_ASSERT_NOW(a_clear_idle, clearing, empty && !o_in_ready, "item during clearing")
    `VSR_ASSERT_NEXT(a_pop_drains, pop && !push, !full, "queue still full after pop")

endmodule

// ===== hw/rtl/vsr_ram.sv =====
module vsr_ram #(
    parameter int W = 8,
    parameter int D = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/vsr_fifo.sv =====
module vsr_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/vsr_front.sv =====
module vsr_front #(
    parameter int MAX_VOXELS = 4096,
    parameter int IW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  vsr_pkg::t_cfg                                 i_cfg,
    input  logic                                          i_block,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic                                          i_kind,
    input  logic [15:0]                                   i_x,
    input  logic [15:0]                                   i_y,
    input  logic [15:0]                                   i_z,
    input  logic [vsr_pkg::N_FEAT-1:0][vsr_pkg::FEAT_W-1:0] i_feat,
    output logic                                          o_push,
    output vsr_pkg::t_cmd                                 o_cmd,
    output logic [IW-1:0]                                 o_idx,
    input  logic                                          i_full
);

    localparam int GW = vsr_pkg::GRID_W;

    logic        r_s1_valid;
    logic        r_s1_kind;
    logic [15:0] r_s1_x;
    logic [15:0] r_s1_y;
    logic [15:0] r_s1_z;
    logic [vsr_pkg::N_FEAT-1:0][vsr_pkg::FEAT_W-1:0] r_s1_feat;

    logic            r_s2_valid;
    logic            r_s2_kind;
    logic            r_s2_rng;
    logic [3*GW-1:0] r_s2_px;
    logic [2*GW-1:0] r_s2_py;
    logic [GW-1:0]   r_s2_z;
    logic [vsr_pkg::N_FEAT-1:0][vsr_pkg::FEAT_W-1:0] r_s2_feat;

    logic [2*GW-1:0] r_yz;
    logic            adv;
    logic            rng;
    logic [3*GW:0]   idx_sum;

    assign adv     = !(r_s2_valid && i_full);
    assign o_ready = adv && !i_block;

    // grid bounds, coordinates below zero fail on the sign bit
    assign rng = !r_s1_x[15] && (r_s1_x < {3'b000, i_cfg.grid_x})
              && !r_s1_y[15] && (r_s1_y < {3'b000, i_cfg.grid_y})
              && !r_s1_z[15] && (r_s1_z < {3'b000, i_cfg.grid_z});

    // linear voxel index and capacity check
    assign idx_sum = {1'b0, r_s2_px} + {{(GW+1){1'b0}}, r_s2_py}
                   + {{(2*GW+1){1'b0}}, r_s2_z};

    assign o_push     = r_s2_valid && !i_full;
    assign o_cmd.kind = r_s2_kind;
    assign o_cmd.ok   = r_s2_rng && (idx_sum < (3*GW+1)'(MAX_VOXELS));
    assign o_cmd.feat = r_s2_feat;
    assign o_idx      = idx_sum[IW-1:0];

    // plane size from the grid registers
    always_ff @(posedge i_clk) begin
        r_yz <= i_cfg.grid_y * i_cfg.grid_z;
    end

    // valid bits of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid && o_ready;
            r_s2_valid <= r_s1_valid;
        end
    end

    // capture and multiply stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind <= i_kind;
            r_s1_x    <= i_x;
            r_s1_y    <= i_y;
            r_s1_z    <= i_z;
            r_s1_feat <= i_feat;
            r_s2_kind <= r_s1_kind;
            r_s2_rng  <= rng;
            r_s2_px   <= r_s1_x[GW-1:0] * r_yz;
            r_s2_py   <= r_s1_y[GW-1:0] * i_cfg.grid_z;
            r_s2_z    <= r_s1_z[GW-1:0];
            r_s2_feat <= r_s1_feat;
        end
    end

endmodule

// ===== hw/rtl/vsr_back.sv =====
module vsr_back #(
    parameter int MAX_VOXELS = 4096,
    parameter int LANES = 8,
    parameter int IW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vsr_pkg::t_cfg               i_cfg,
    output logic                        o_clearing,
    input  logic                        i_empty,
    input  vsr_pkg::t_cmd               i_cmd,
    input  logic [IW-1:0]               i_idx,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vsr_pkg::ACC_W-1:0]   o_lane [vsr_pkg::N_FEAT],
    output logic [vsr_pkg::CNT_W-1:0]   o_count,
    output logic                        o_in_range
);

    localparam int AW = vsr_pkg::ACC_W;
    localparam int CW = vsr_pkg::CNT_W;
    localparam int NF = vsr_pkg::N_FEAT;
    localparam int RW = LANES*AW + CW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state        r_state;
    logic          r_clr;
    logic [IW-1:0] r_clr_addr;
    vsr_pkg::t_cmd r_cmd;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic          r_rng;
    logic [AW-1:0] r_res [NF];
    logic [NF-1:0] r_neg;
    logic [CW-1:0] r_rem [NF];
    logic [4:0]    r_step;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_q;
    logic [RW-1:0] upd_word;
    logic [CW-1:0] q_cnt;
    logic [3:0]    used;
    logic          is_max;
    logic          is_mean;
    logic [AW-1:0] div_res [NF];
    logic [CW-1:0] div_rem [NF];

    assign o_clearing = r_clr;
    assign o_pop      = (r_state == ST_IDLE) && !i_empty && !r_clr;
    assign q_cnt      = ram_q[RW-1 -: CW];
    assign used       = (i_cfg.feats > 4'(LANES)) ? 4'(LANES) : i_cfg.feats;
    assign is_max     = (i_cfg.mode == vsr_pkg::MODE_MAX);
    assign is_mean    = (i_cfg.mode == vsr_pkg::MODE_MEAN);

    // updated voxel word for a scatter
    always_comb begin
        logic signed [AW-1:0]     a;
        logic signed [AW-1:0]     f;
        logic signed [AW:0]       s;
        logic [AW-1:0]            v;
        upd_word = ram_q;
        for (int d = 0; d < LANES; d++) begin
            a = ram_q[d*AW +: AW];
            f = AW'(signed'(r_cmd.feat[d]));
            s = {a[AW-1], a} + {f[AW-1], f};
            if (is_max) begin
                v = ((q_cnt == '0) || (f > a)) ? f : a;
            end else if (s[AW] != s[AW-1]) begin
                v = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end else begin
                v = s[AW-1:0];
            end
            if (4'(d) < used) begin
                upd_word[d*AW +: AW] = v;
            end
        end
        if (is_max) begin
            upd_word[RW-1 -: CW] = CW'(1);
        end else if (q_cnt != {CW{1'b1}}) begin
            upd_word[RW-1 -: CW] = q_cnt + 1'b1;
        end
    end

    // one restoring division step per lane
    always_comb begin
        logic [CW:0] rs;
        for (int d = 0; d < NF; d++) begin
            rs = {r_rem[d], r_res[d][AW-1]};
            if (rs >= {1'b0, r_cnt}) begin
                div_rem[d] = CW'(rs - {1'b0, r_cnt});
                div_res[d] = {r_res[d][AW-2:0], 1'b1};
            end else begin
                div_rem[d] = rs[CW-1:0];
                div_res[d] = {r_res[d][AW-2:0], 1'b0};
            end
        end
    end

    // store write: clearing sweep, scatter update or clear on read
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        if (r_clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end else if ((r_state == ST_EXEC) && r_cmd.ok) begin
            ram_we = 1'b1;
            if (r_cmd.kind == vsr_pkg::KIND_SCATTER) begin
                ram_wdata = upd_word;
            end
        end
    end

    vsr_ram #(
        .W (RW),
        .D (MAX_VOXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop),
        .i_raddr (i_idx),
        .o_rdata (ram_q)
    );

    // sequencer, result staging and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != ST_OUT)) begin
                o_valid <= 1'b0;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(MAX_VOXELS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= i_idx;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (r_cmd.kind == vsr_pkg::KIND_SCATTER) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_rng  <= r_cmd.ok;
                        r_cnt  <= r_cmd.ok ? q_cnt : '0;
                        r_step <= '0;
                        for (int d = 0; d < NF; d++) begin
                            logic [AW-1:0] a;
                            a = '0;
                            if ((d < LANES) && r_cmd.ok && (q_cnt != '0)
                                && (4'(d) < used)) begin
                                a = ram_q[(d % LANES)*AW +: AW];
                            end
                            r_rem[d] <= '0;
                            if (is_mean) begin
                                r_res[d] <= a[AW-1] ? (~a + 1'b1) : a;
                                r_neg[d] <= a[AW-1];
                            end else begin
                                r_res[d] <= a;
                                r_neg[d] <= 1'b0;
                            end
                        end
                        if (is_mean && r_cmd.ok && (q_cnt != '0)) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    for (int d = 0; d < NF; d++) begin
                        r_res[d] <= div_res[d];
                        r_rem[d] <= div_rem[d];
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd31) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_count    <= r_cnt;
                        o_in_range <= r_rng;
                        for (int d = 0; d < NF; d++) begin
                            o_lane[d] <= r_neg[d] ? (~r_res[d] + 1'b1) : r_res[d];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
